>>> design/mbet_pkg.sv
// Package for the Mandelbrot escape-time block: field widths, Q4.28 constants,
// register indexes and the structs passed between the controller and datapath.
// No dependencies; every other design file imports it.
package mbet_pkg;

   // Field widths.
   localparam int PIX_W     = 10;
   localparam int Q_W       = 32;
   localparam int STEP_W    = 31;
   localparam int CNT_OUT_W = 9;
   localparam int PROD_W    = 2 * Q_W;
   localparam int WIDE_W    = PROD_W + 2;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4).
   localparam logic [1:0] REG_ORIGIN_RE = 2'd0;
   localparam logic [1:0] REG_ORIGIN_IM = 2'd1;
   localparam logic [1:0] REG_STEP_RE   = 2'd2;
   localparam logic [1:0] REG_STEP_IM   = 2'd3;

   // Register reset values in Q4.28.
   localparam logic signed [Q_W-1:0]  ORIGIN_RE_RESET = -32'sd671088640;
   localparam logic signed [Q_W-1:0]  ORIGIN_IM_RESET = -32'sd536870912;
   localparam logic [STEP_W-1:0]      STEP_RE_RESET   = 31'd1048576;
   localparam logic [STEP_W-1:0]      STEP_IM_RESET   = 31'd1048576;

   // Escape threshold 4.0 in Q8.56 and the rounding halves for the two shifts.
   localparam logic [PROD_W:0]         FOUR_Q856   = 65'd1 << 58;
   localparam logic signed [WIDE_W-1:0] HALF_SHR28 = 66'sd134217728;
   localparam logic signed [WIDE_W-1:0] HALF_SHR27 = 66'sd67108864;

   // Q4.28 limits, sign-extended to the wide working width.
   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE = -66'sd2147483648;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [Q_W-1:0] origin_re;
      logic signed [Q_W-1:0] origin_im;
      logic [STEP_W-1:0]     step_re;
      logic [STEP_W-1:0]     step_im;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the pixel of an accepted transaction
      logic map;     // compute c and clear z and the count
      logic mul;     // register the three products of z
      logic update;  // advance z and the count by one iteration
      logic emit;    // load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;    // escaped or reached the iteration limit
   } dp_status_type;

   // Clamp a wide signed value to the Q4.28 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX_WIDE) begin
         r = Q_MAX_WIDE[Q_W-1:0];
      end else if (v < Q_MIN_WIDE) begin
         r = Q_MIN_WIDE[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/mbet_if.sv
// Valid/ready channel interfaces for the pixel requests and escape-count responses.
// Depends on mbet_pkg for the field widths.
interface mbet_req_if;
   import mbet_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbet_rsp_if;
   import mbet_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     out_x;
   logic [PIX_W-1:0]     out_y;
   logic [CNT_OUT_W-1:0] iteration_count;

   modport source (output valid, output out_x, output out_y, output iteration_count,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input iteration_count,
                   output ready);
endinterface

>>> design/mbet_csr.sv
// APB-style configuration registers: view origin and per-pixel step.
// Depends on mbet_pkg for the register indexes, reset values and cfg_type.
module mbet_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mbet_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mbet_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output mbet_pkg::cfg_type                  cfg
);
   import mbet_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ORIGIN_RE: cfg_in.origin_re = $signed(csr_pwdata[Q_W-1:0]);
            REG_ORIGIN_IM: cfg_in.origin_im = $signed(csr_pwdata[Q_W-1:0]);
            REG_STEP_RE:   cfg_in.step_re   = csr_pwdata[STEP_W-1:0];
            REG_STEP_IM:   cfg_in.step_im   = csr_pwdata[STEP_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_re <= ORIGIN_RE_RESET;
         cfg_ff.origin_im <= ORIGIN_IM_RESET;
         cfg_ff.step_re   <= STEP_RE_RESET;
         cfg_ff.step_im   <= STEP_IM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_RE: csr_prdata = cfg_ff.origin_re;
         REG_ORIGIN_IM: csr_prdata = cfg_ff.origin_im;
         REG_STEP_RE:   csr_prdata = {1'b0, cfg_ff.step_re};
         REG_STEP_IM:   csr_prdata = {1'b0, cfg_ff.step_im};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> design/mbet_ctrl.sv
// Controller state machine: sequences point mapping, the multiply/update
// iteration loop and the result register. Depends on mbet_pkg.
module mbet_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mbet_pkg::ctrl_cmd_type  cmd,
   input  mbet_pkg::dp_status_type status
);
   import mbet_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAP  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_UPD  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The result register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (status.done) begin
               state_in = ST_FIN;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The result stays valid until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // An accepted transaction always starts with point mapping.
   a_accept_maps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAP))
      else $error("accepted transaction did not enter mapping");

   // An unfinished iteration always loops back to the multiply step.
   a_loop_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && !status.done) |=> (state_ff == ST_MUL))
      else $error("iteration loop did not return to multiply");
`endif

endmodule

>>> design/mbet_datapath.sv
// Datapath: pixel-to-point mapping, Q4.28 z*z + c iteration with registered
// products, escape test, iteration counter and result register. Depends on mbet_pkg.
module mbet_datapath #(
   parameter int ITERATION_LIMIT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mbet_pkg::cfg_type                    cfg,
   input  mbet_pkg::ctrl_cmd_type               cmd,
   output mbet_pkg::dp_status_type              status,
   input  logic [mbet_pkg::PIX_W-1:0]           pixel_x,
   input  logic [mbet_pkg::PIX_W-1:0]           pixel_y,
   output logic [mbet_pkg::PIX_W-1:0]           out_x,
   output logic [mbet_pkg::PIX_W-1:0]           out_y,
   output logic [mbet_pkg::CNT_OUT_W-1:0]       iteration_count
);
   import mbet_pkg::*;

   localparam int CNT_W  = $clog2(ITERATION_LIMIT + 1);
   localparam int CNT_XW = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

   logic [PIX_W-1:0]         px_ff, py_ff;
   logic signed [Q_W-1:0]    cr_ff, ci_ff, cr_in, ci_in;
   logic signed [Q_W-1:0]    zr_ff, zi_ff, zr_in, zi_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [PIX_W-1:0]         out_x_ff, out_y_ff;
   logic [CNT_OUT_W-1:0]     out_cnt_ff;
   logic [CNT_XW-1:0]        cnt_ext;

   logic signed [PIX_W+Q_W:0]  map_re, map_im;
   logic signed [WIDE_W-1:0]   map_re_sum, map_im_sum;
   logic [PROD_W:0]            mag_sum;
   logic                       escaped;
   logic signed [WIDE_W-1:0]   re_round, im_round, re_sum, im_sum;

   // Point mapping: c = pixel * step + origin, exact, then clamped.
   assign map_re     = $signed({1'b0, px_ff}) * $signed({1'b0, cfg.step_re});
   assign map_im     = $signed({1'b0, py_ff}) * $signed({1'b0, cfg.step_im});
   assign map_re_sum = WIDE_W'(map_re) + WIDE_W'(cfg.origin_re);
   assign map_im_sum = WIDE_W'(map_im) + WIDE_W'(cfg.origin_im);
   assign cr_in      = sat_q(map_re_sum);
   assign ci_in      = sat_q(map_im_sum);

   // Escape test on the exact Q8.56 magnitude.
   assign mag_sum = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign escaped = (mag_sum >= FOUR_Q856);
   assign status.done = escaped || (cnt_ff == CNT_W'(ITERATION_LIMIT));

   // Next z: round half up back to Q4.28, add c, clamp.
   assign re_round = (WIDE_W'(rr_ff) - WIDE_W'(ii_ff) + HALF_SHR28) >>> 28;
   assign im_round = (WIDE_W'(ri_ff) + HALF_SHR27) >>> 27;
   assign re_sum   = re_round + WIDE_W'(cr_ff);
   assign im_sum   = im_round + WIDE_W'(ci_ff);
   assign zr_in    = sat_q(re_sum);
   assign zi_in    = sat_q(im_sum);

   // Counts above nine bits are reported modulo 512.
   assign cnt_ext = CNT_XW'(cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.map) begin
         cr_ff  <= cr_in;
         ci_ff  <= ci_in;
         zr_ff  <= '0;
         zi_ff  <= '0;
         cnt_ff <= '0;
      end
      if (cmd.mul) begin
         rr_ff <= zr_ff * zr_ff;
         ii_ff <= zi_ff * zi_ff;
         ri_ff <= zr_ff * zi_ff;
      end
      if (cmd.update) begin
         zr_ff  <= zr_in;
         zi_ff  <= zi_in;
         cnt_ff <= CNT_W'(cnt_ff + 1'b1);
      end
      if (cmd.emit) begin
         out_x_ff   <= px_ff;
         out_y_ff   <= py_ff;
         out_cnt_ff <= cnt_ext[CNT_OUT_W-1:0];
      end
   end

   assign out_x           = out_x_ff;
   assign out_y           = out_y_ff;
   assign iteration_count = out_cnt_ff;

`ifndef SYNTHESIS
   // An iteration is only taken while the count is below the limit.
   a_cnt_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (cnt_ff < CNT_W'(ITERATION_LIMIT)))
      else $error("iteration taken at the limit");

   // Mapping starts every pixel from z = 0 with a zero count.
   a_map_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.map |=> (zr_ff == '0 && zi_ff == '0 && cnt_ff == '0))
      else $error("mapping did not clear the iterate");
`endif

endmodule

>>> design/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: channel interfaces, APB
// configuration, controller and datapath. Depends on mbet_pkg, mbet_if,
// mbet_csr, mbet_ctrl and mbet_datapath.
//
// Usage:
//   req_ch carries one pixel (pixel_x, pixel_y) per transaction; rsp_ch
//   returns one transaction per pixel with out_x, out_y and iteration_count.
//   The csr_ port sets origin_re, origin_im, step_re and step_im (Q4.28) at
//   byte addresses 0, 4, 8 and 12; write it only while the block is idle.
//   One pixel is processed at a time. After acceptance the point is mapped,
//   then each iteration has a multiply step (the three registered 32x32
//   products) and an update step (the escape test and the z update); after
//   the final test the result register is loaded as soon as it is free,
//   and then the next pixel can be accepted.
//   req_ch is ready only when no pixel is in flight.
//   The result register holds a finished result while rsp_ch is stalled and
//   a new pixel can be accepted meanwhile; its result waits if the register
//   is still full. Reset clears the controller and loads the register
//   defaults (origin -2.5 - 2.0i, step 1/256).
module mandelbrot_escape_time #(
   parameter int ITERATION_LIMIT = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   mbet_req_if.sink                        req_ch,
   mbet_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mbet_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbet_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbet_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mbet_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // Configuration registers.
   mbet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   mbet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and result register.
   mbet_datapath #(
      .ITERATION_LIMIT (ITERATION_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .pixel_x         (req_ch.pixel_x),
      .pixel_y         (req_ch.pixel_y),
      .out_x           (rsp_ch.out_x),
      .out_y           (rsp_ch.out_y),
      .iteration_count (rsp_ch.iteration_count)
   );

   // Channel handshakes.
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

>>> bench/mandelbrot_escape_time_tb.sv
// Self-checking testbench for mandelbrot_escape_time: directed probe table, then random views.
// Depends on mbet_pkg, mbet_if and the mandelbrot_escape_time RTL; escape counts are predicted
// by a fixed-point escape-time predictor held in this file.
module mandelbrot_escape_time_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbet_pkg::*;

   localparam int ITER_LIMIT = 256;
   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES = 1500;
   localparam int RANDOM_PHASES = 6;
   localparam int PIXELS_PER_PHASE = 84;
   localparam real TIMEOUT_NS = 2_000_000 * 12.0;

   localparam longint Q_TOP = 64'sd2147483647;
   localparam longint Q_BOTTOM = -64'sd2147483648;

   // Raw register words used by the probe table.
   localparam logic [31:0] DEF_ORE = ORIGIN_RE_RESET;
   localparam logic [31:0] DEF_OIM = ORIGIN_IM_RESET;
   localparam logic [31:0] DEF_STEP = 32'(STEP_RE_RESET);
   localparam logic [31:0] Q_LO = 32'h8000_0000;
   localparam logic [31:0] Q_HI = 32'h7FFF_FFFF;
   localparam logic [31:0] STEP_BIT31 = 32'h8000_0000;  // only the unused top bit set

   typedef enum logic [1:0] {MODE_SEND32_RECV56, MODE_SEND56_RECV32, MODE_NO_IDLE} idle_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0]     x;
      logic [PIX_W-1:0]     y;
      logic [CNT_OUT_W-1:0] count;
   } escape_result_type;

   typedef struct packed {
      logic [31:0]          ore;
      logic [31:0]          oim;
      logic [31:0]          sre;
      logic [31:0]          sim;
      logic [PIX_W-1:0]     px;
      logic [PIX_W-1:0]     py;
      logic                 known;
      logic [CNT_OUT_W-1:0] count;
   } probe_row_type;

   localparam int PROBES = 23;
   localparam probe_row_type PROBE_TABLE [PROBES] = '{
      // Reset view: corners, the origin of the plane and mixed bit patterns.
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd0, 10'd0, 1'b1, 9'd1},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd1023, 10'd1023, 1'b1, 9'd1},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd640, 10'd512, 1'b1, 9'd256},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd1023, 10'd0, 1'b0, 9'd0},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd0, 10'd1023, 1'b0, 9'd0},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'd576, 10'd512, 1'b0, 9'd0},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'h155, 10'h2AA, 1'b0, 9'd0},
      '{DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP, 10'h2AA, 10'h155, 1'b0, 9'd0},
      // Most negative corner; the step words carry only the ignored top bit.
      '{Q_LO, Q_LO, STEP_BIT31, STEP_BIT31, 10'd1023, 10'd1023, 1'b1, 9'd1},
      '{Q_LO, Q_LO, STEP_BIT31, STEP_BIT31, 10'd0, 10'd0, 1'b1, 9'd1},
      // Most positive corner with the largest step: c saturates high.
      '{Q_HI, Q_HI, Q_HI, Q_HI, 10'd0, 10'd0, 1'b1, 9'd1},
      '{Q_HI, Q_HI, Q_HI, Q_HI, 10'd1023, 10'd1023, 1'b1, 9'd1},
      // Most negative corner with the largest step: high saturation and a point next to zero.
      '{Q_LO, Q_LO, Q_HI, Q_HI, 10'd1023, 10'd0, 1'b1, 9'd1},
      '{Q_LO, Q_LO, Q_HI, Q_HI, 10'd1, 10'd1, 1'b0, 9'd0},
      // c = 0 never escapes.
      '{32'h0, 32'h0, 32'h0, 32'h0, 10'd512, 10'd512, 1'b1, 9'd256},
      // c = -2 lands exactly on the escape radius after one iteration.
      '{32'hE000_0000, 32'h0, 32'h0, 32'h0, 10'd0, 10'd0, 1'b1, 9'd1},
      // c = -1 and c = i are bounded cycles.
      '{32'hF000_0000, 32'h0, 32'h0, 32'h0, 10'd1, 10'd2, 1'b0, 9'd0},
      '{32'h0, 32'h1000_0000, 32'h0, 32'h0, 10'd3, 10'd4, 1'b0, 9'd0},
      // Around the cusp at 0.25, where escape is slow.
      '{32'h0400_0000, 32'h0, 32'h1000, 32'h1000, 10'd0, 10'd0, 1'b0, 9'd0},
      '{32'h0400_0000, 32'h0, 32'h1000, 32'h1000, 10'd1, 10'd0, 1'b0, 9'd0},
      '{32'h0400_0000, 32'h0, 32'h1000, 32'h1000, 10'd0, 10'd1023, 1'b0, 9'd0},
      // Along the neck at -0.75.
      '{32'hF400_0000, 32'h0, 32'h1, 32'h400, 10'd0, 10'd5, 1'b0, 9'd0},
      '{32'hF400_0000, 32'h0, 32'h1, 32'h400, 10'd0, 10'd100, 1'b0, 9'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   mbet_req_if req_if ();
   mbet_rsp_if rsp_if ();

   mandelbrot_escape_time #(.ITERATION_LIMIT(ITER_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the view registers.
   logic signed [31:0] cfg_origin_re = ORIGIN_RE_RESET;
   logic signed [31:0] cfg_origin_im = ORIGIN_IM_RESET;
   logic [30:0] cfg_step_re = STEP_RE_RESET;
   logic [30:0] cfg_step_im = STEP_IM_RESET;
   logic [127:0] applied_view = {DEF_ORE, DEF_OIM, DEF_STEP, DEF_STEP};

   escape_result_type pixels_in_flight [$];
   int mismatches = 0;
   idle_mode_type idle_mode = MODE_SEND32_RECV56;
   int hold_reqs = 0;
   int hold_served = 0;
   int hold_left = 0;

   always #6 clock = ~clock;

   // Clamp a wide value to the Q4.28 range.
   function automatic longint clamp_q(input longint v);
      if (v > Q_TOP) begin
         return Q_TOP;
      end else if (v < Q_BOTTOM) begin
         return Q_BOTTOM;
      end
      return v;
   endfunction

   // Divide by 2^s, rounding halves toward plus infinity.
   function automatic longint round_shr(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint map_coord(input longint pix, input longint step, input longint org);
      return clamp_q(pix * step + org);
   endfunction

   // Escape-time count for one pixel under the current view.
   function automatic logic [CNT_OUT_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                         input logic [PIX_W-1:0] py);
      longint cr, ci, zr, zi, rr, ii, ri, nr;
      logic [64:0] mag;
      int n;
      cr = map_coord(px, cfg_step_re, cfg_origin_re);
      ci = map_coord(py, cfg_step_im, cfg_origin_im);
      zr = 0;
      zi = 0;
      n = 0;
      while (n < ITER_LIMIT) begin
         rr = zr * zr;
         ii = zi * zi;
         mag = 65'(rr) + 65'(ii);
         if (mag >= FOUR_Q856) break;
         ri = zr * zi;
         nr = clamp_q(round_shr(rr - ii, 28) + cr);
         zi = clamp_q(round_shr(ri, 27) + ci);
         zr = nr;
         n++;
      end
      return n[CNT_OUT_W-1:0];
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   // One APB write: setup phase, access phase, then a quiet phase.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Write all four view registers and mirror them in the predictor.
   task automatic write_view(input logic [31:0] ore, input logic [31:0] oim,
                             input logic [31:0] sre, input logic [31:0] sim);
      csr_write(REG_ORIGIN_RE, ore);
      csr_write(REG_ORIGIN_IM, oim);
      csr_write(REG_STEP_RE, sre);
      csr_write(REG_STEP_IM, sim);
      cfg_origin_re = ore;
      cfg_origin_im = oim;
      cfg_step_re = sre[30:0];
      cfg_step_im = sim[30:0];
      applied_view = {ore, oim, sre, sim};
   endtask

   // Stop offering and wait for every outstanding result.
   task automatic drain_pixels();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pixels_in_flight.size() != 0);
   endtask

   // Offer one pixel, with a random gap first, and record its expected result.
   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                             input logic known, input logic [CNT_OUT_W-1:0] known_count);
      escape_result_type due;
      int gap_pct;
      gap_pct = (idle_mode == MODE_SEND32_RECV56) ? 32 :
                (idle_mode == MODE_SEND56_RECV32) ? 56 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_x <= px;
      req_if.pixel_y <= py;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      due.x = px;
      due.y = py;
      due.count = known ? known_count : escape_count(px, py);
      pixels_in_flight.push_back(due);
   endtask

   // Result receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = (idle_mode == MODE_SEND32_RECV56) ? 56 :
                  (idle_mode == MODE_SEND56_RECV32) ? 32 : 0;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_reqs != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each result transaction with the oldest expected one.
   always @(posedge clock) begin
      escape_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pixels_in_flight.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result x=%0d y=%0d count=%0d", $realtime,
                        rsp_if.out_x, rsp_if.out_y, rsp_if.iteration_count);
            end
         end else begin
            want = pixels_in_flight.pop_front();
            if (rsp_if.out_x !== want.x) note_mismatch("out_x", want.x, rsp_if.out_x);
            if (rsp_if.out_y !== want.y) note_mismatch("out_y", want.y, rsp_if.out_y);
            if (rsp_if.iteration_count !== want.count) begin
               note_mismatch("iteration_count", want.count, rsp_if.iteration_count);
            end
         end
      end
   end

   // Stimulus: probe table, then random views under each idling mode.
   initial begin
      int center_re;
      int center_im;
      int step;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      rsp_if.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PROBES; r++) begin
         if ({PROBE_TABLE[r].ore, PROBE_TABLE[r].oim, PROBE_TABLE[r].sre,
              PROBE_TABLE[r].sim} != applied_view) begin
            drain_pixels();
            write_view(PROBE_TABLE[r].ore, PROBE_TABLE[r].oim, PROBE_TABLE[r].sre,
                       PROBE_TABLE[r].sim);
         end
         send_pixel(PROBE_TABLE[r].px, PROBE_TABLE[r].py, PROBE_TABLE[r].known,
                    PROBE_TABLE[r].count);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_pixels();
         idle_mode <= idle_mode_type'(p / 2);
         if (p == 3) begin
            // Arbitrary register words: mostly saturated points that escape at once.
            write_view($urandom, $urandom, $urandom, $urandom);
         end else begin
            // A window of 1024 pixels around a random point near the set.
            center_re = int'($urandom_range(3 << 28)) - (2 << 28);
            center_im = int'($urandom_range(2 << 28)) - (1 << 28);
            step = int'($urandom_range(1 << 20, 1 << 12));
            write_view(center_re - 512 * step, center_im - 512 * step,
                       {1'($urandom_range(1)), 31'(step)}, {1'($urandom_range(1)), 31'(step)});
         end
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            if (p == 1 && i == 10) hold_reqs <= hold_reqs + 1;
            if (p == 4 && i == 40) drain_pixels();
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
